// ----- sv/fkp_pkg.sv -----
// Package for the FASTA k-mer packer: field widths, character codes and classifier.
`timescale 1ns / 1ps
`default_nettype none

package fkp_pkg;

    localparam int CHAR_W  = 8;
    localparam int Q_LEN_W = 6;
    localparam int KEY_W   = 64;
    localparam int BASE_W  = 2;

    localparam logic [Q_LEN_W-1:0] Q_LEN_RESET = 6'd32;

    localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_C   = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_UP_G   = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_UP_T   = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_C   = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LO_G   = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LO_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;

    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    typedef enum logic [1:0] {
        CLS_BASE,
        CLS_NEWLINE,
        CLS_HEADER,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t       cls;
        logic [BASE_W-1:0] base;
    } char_info_t;

    function automatic char_info_t classify_char(input logic [CHAR_W-1:0] b);
        char_info_t info;
        info.cls  = CLS_BASE;
        info.base = BASE_A;
        case (b)
            CHAR_UP_A, CHAR_LO_A: info.base = BASE_A;
            CHAR_UP_C, CHAR_LO_C: info.base = BASE_C;
            CHAR_UP_G, CHAR_LO_G: info.base = BASE_G;
            CHAR_UP_T, CHAR_LO_T: info.base = BASE_T;
            CHAR_NL:              info.cls  = CLS_NEWLINE;
            CHAR_GT, CHAR_SEMI:   info.cls  = CLS_HEADER;
            default:              info.cls  = CLS_OTHER;
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fasta_kmer_packer.sv -----
// Top level of the FASTA k-mer packer: classifies text bytes and emits packed k-mer keys.
//
// The slave stream takes one byte of FASTA text per beat in s_axis_tdata. Bases A, C, G
// and T in either case are coded 0..3 and shifted into a rolling key, newest base in the
// low two bits. From the q_length-th base of a run without a break on, every base
// gives one beat on the master stream: the last q_length bases in the low 2*q_length
// bits of m_axis_tdata, upper bits zero. Newlines are skipped, '>' or ';' start a header
// that lasts up to and including the next newline, and any other byte clears the run.
// q_length is written through cfg_we / cfg_wdata only while the stream is idle; the user
// keeps to this, the block does not enforce it. Zero acts as one, above MAX_Q as MAX_Q.
// A byte is accepted in every cycle while s_axis_tready is high. Its key goes into the
// output register, or into the one-beat skid register behind it while that register
// holds a stalled key, so a byte is still taken while a key waits; s_axis_tready
// drops only when both hold keys and the receiver stalls. Reset clears the key, the run
// count and header mode, empties both output registers and sets q_length to 32.
`timescale 1ns / 1ps
`default_nettype none

module fasta_kmer_packer
    import fkp_pkg::*;
#(
    parameter int MAX_Q = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [Q_LEN_W-1:0] cfg_wdata,       // q_length
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [CHAR_W-1:0]  s_axis_tdata,    // [7:0] char_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [KEY_W-1:0]        m_axis_tdata     // [63:0] kmer_key
);

    localparam int RKEY_W = BASE_W * MAX_Q;
    localparam int RUN_W  = $clog2(MAX_Q + 1);
    localparam logic [Q_LEN_W-1:0] MAX_Q_LEN = Q_LEN_W'(MAX_Q);

    logic [Q_LEN_W-1:0] q_len_reg;
    logic [RKEY_W-1:0]  key_reg, key_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic               hdr_reg, hdr_next;
    logic               out_valid_reg, skid_valid_reg;
    logic [KEY_W-1:0]   out_data_reg, skid_data_reg;

    char_info_t         info;
    logic [Q_LEN_W-1:0] q_eff;
    logic [RUN_W-1:0]   q_run;
    logic [RUN_W-1:0]   run_inc;
    logic [RKEY_W-1:0]  key_shift;
    logic [RKEY_W-1:0]  key_mask;
    logic               emit;
    logic [KEY_W-1:0]   emit_key;
    logic               in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign info = classify_char(s_axis_tdata);

    always_comb
    begin
        q_eff = q_len_reg;
        if (q_len_reg == '0)
        begin
            q_eff = Q_LEN_W'(1);
        end
        else if (q_len_reg > MAX_Q_LEN)
        begin
            q_eff = MAX_Q_LEN;
        end
    end

    assign q_run     = RUN_W'(q_eff);
    assign run_inc   = run_reg + RUN_W'(1);
    assign key_shift = (key_reg << BASE_W) | RKEY_W'(info.base);

    always_comb
    begin
        for (int i = 0; i < RKEY_W; i++)
        begin
            key_mask[i] = (Q_LEN_W'(i / BASE_W) < q_eff);
        end
    end

    assign emit_key = KEY_W'(key_shift & key_mask);

    always_comb
    begin
        key_next = key_reg;
        run_next = run_reg;
        hdr_next = hdr_reg;
        emit     = 1'b0;
        if (in_fire)
        begin
            if (hdr_reg)
            begin
                if (info.cls == CLS_NEWLINE)
                begin
                    hdr_next = 1'b0;
                end
            end
            else
            begin
                case (info.cls)
                    CLS_BASE:
                    begin
                        key_next = key_shift;
                        if (run_inc >= q_run)
                        begin
                            run_next = q_run - RUN_W'(1);
                            emit     = 1'b1;
                        end
                        else
                        begin
                            run_next = run_inc;
                        end
                    end
                    CLS_NEWLINE:
                    begin
                        key_next = key_reg;
                    end
                    CLS_HEADER:
                    begin
                        key_next = '0;
                        run_next = '0;
                        hdr_next = 1'b1;
                    end
                    default:
                    begin
                        key_next = '0;
                        run_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_len_reg <= Q_LEN_RESET;
            key_reg   <= '0;
            run_reg   <= '0;
            hdr_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                q_len_reg <= cfg_wdata;
            end
            key_reg <= key_next;
            run_reg <= run_next;
            hdr_reg <= hdr_next;
        end
    end

    // Output register with a one-beat skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (emit)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= emit_key;
            end
            else
            begin
                out_data_reg <= emit_key;
            end
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/fkp_checker.sv -----
// Port-level checker for the FASTA k-mer packer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fkp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_we,
    input wire logic [5:0]  cfg_wdata,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // A stalled key stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("fkp: stalled output beat changed");

    // Input backpressure only happens while a key is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("fkp: input stalled with empty output");

    // A new output beat always follows an accepted input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("fkp: output beat without accepted input");

    // The skid register fills only when a byte arrives during an output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && m_axis_tvalid && !m_axis_tready))
        else $error("fkp: input ready dropped without output stall");

endmodule

bind fasta_kmer_packer fkp_checker u_fkp_checker (.*);

`default_nettype wire
